// ===== hw/rtl/bfa_pkg.sv =====
package bfa_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = 13;
	localparam int FRAME_W   = 12;
	localparam int MODE_W    = 3;
	localparam int STAT_W    = 2;
	localparam int TOTAL_W   = 13;

	localparam logic [TOTAL_W-1:0]   TOTAL_RESET = 13'd4096;
	localparam logic [CNT_W-1:0]     USED_RESET  = 13'd4096;
	localparam logic [WORD_BITS-1:0] FULL_WORD   = 32'hffffffff;

	// request modes
	localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FREE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AVAIL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

	// saturating subtract, floor at zero
	function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	// saturating add, capped at lim
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] lim);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, lim}) ? lim : s[CNT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/bfa_if.sv =====
interface bfa_req_if import bfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] start_frame;
	logic [CNT_W-1:0]   count;
	modport source (output valid, mode, start_frame, count, input ready);
	modport sink (input valid, mode, start_frame, count, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] frame;
	logic [CNT_W-1:0]   used_frames;
	logic [CNT_W-1:0]   free_frames;
	modport source (output valid, status, frame, used_frames, free_frames, input ready);
	modport sink (input valid, status, frame, used_frames, free_frames, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/bfa_map_mem.sv =====
module bfa_map_mem import bfa_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/bfa_word_search.sv =====
module bfa_word_search import bfa_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	input  logic                 is_last,
	input  logic [4:0]           lim,
	input  logic [CNT_W-1:0]     cnt,
	input  logic [CNT_W-1:0]     run_in,
	output logic                 hit,
	output logic [4:0]           pos,
	output logic [CNT_W-1:0]     run_out
);

	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] f;
	logic [WORD_BITS-1:0] f1, f2, f3, f4, f5;
	logic [WORD_BITS-1:0] win;
	logic [WORD_BITS-1:0] cont;
	logic [WORD_BITS-1:0] hitv;
	logic [4:0]           hi_used;

	// free bits, frames past the managed total count as used
	always_comb begin
		vmask = is_last ? (FULL_WORD >> (5'd31 - lim)) : FULL_WORD;
		f     = ~word & vmask;
		f1    = f & (f << 1);
		f2    = f1 & (f1 << 2);
		f3    = f2 & (f2 << 4);
		f4    = f3 & (f3 << 8);
		f5    = f4 & (f4 << 16);
	end

	// runs wholly inside this word: two overlapping power-of-two windows
	always_comb begin
		if (cnt == 13'd32) begin
			win = f5;
		end else if (cnt[12:5] != '0) begin
			win = '0;
		end else if (cnt[4]) begin
			win = f4 & (f4 << cnt[3:0]);
		end else if (cnt[3]) begin
			win = f3 & (f3 << cnt[2:0]);
		end else if (cnt[2]) begin
			win = f2 & (f2 << cnt[1:0]);
		end else if (cnt[1]) begin
			win = f1 & (f1 << cnt[0]);
		end else if (cnt[0]) begin
			win = f;
		end else begin
			win = '0;
		end
	end

	// runs continuing from earlier words
	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			cont[p] = (&(f | ~(FULL_WORD >> (31 - p))))
				&& (({1'b0, run_in} + 14'(p) + 14'd1) >= {1'b0, cnt});
		end
	end

	// lowest hit position
	always_comb begin
		hitv = win | cont;
		hit  = |hitv;
		pos  = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (hitv[p]) begin
				pos = 5'(p);
			end
		end
	end

	// free run left at the top of the word
	always_comb begin
		hi_used = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			if (!f[p]) begin
				hi_used = 5'(p);
			end
		end
		if (&f) begin
			run_out = run_in + 13'd32;
		end else begin
			run_out = {8'd0, 5'd31 - hi_used};
		end
	end

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Bitmap frame allocator: one used bit per frame kept in a word-wide map memory,
// plus a used-frame count.
// Channels: req (mode, start_frame, count) in, rsp (status, frame, used_frames,
// free_frames) out, cfg writes total_frames (always ready; write it only idle).
// One request is worked at a time; req.ready is high only when the control is idle.
// Requests that fail the error or out-of-memory checks made at accept go from
// idle straight to the done state. Alloc reads one map word per cycle for the run
// search (up to total_frames/32 words, rounded up) and then rewrites the run one
// word per cycle; free, make available and reserve rewrite only the words the run
// covers, and make available then rewrites word 0 to set frame 0. Init rewrites the
// whole map.
// After reset the map is swept to all ones with req.ready low;
// total_frames resets to 4096 and the used count to 4096.
// A finished result waits in the output register; while rsp.ready is low the
// next request can be taken and worked, but its result holds until the output
// register is free.
module bitmap_frame_allocator import bfa_pkg::*; #(
	parameter int FRAMES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	bfa_req_if.sink   req,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink   cfg
);

	localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = $clog2(MAP_WORDS);
	localparam int TOT_CAP   = (FRAMES > 8191) ? 8191 : FRAMES;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_FIX_RD = 7'b0010000,
		S_FIX_WR = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CNT_W-1:0]     used_q;
	logic [MODE_W-1:0]    mode_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     rs_q, re_q;
	logic [AW-1:0]        wlo_q, whi_q, last_q;
	logic                 set_q;
	logic                 init_q;
	logic [STAT_W-1:0]    status_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [AW-1:0]        addr_q;
	logic                 iss_done_q;
	logic [CNT_W-1:0]     run_q;
	logic                 vld_s1;
	logic [AW-1:0]        addr_s1;
	logic                 out_vld_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [FRAME_W-1:0]   out_frame_q;
	logic [CNT_W-1:0]     out_used_q;
	logic [CNT_W-1:0]     out_free_q;

	logic [CNT_W-1:0]     tot, tot_m1, freec;
	logic                 rd_issue, mem_we;
	logic [AW-1:0]        raddr, waddr;
	logic [WORD_BITS-1:0] wdata, rdata, wmask;
	logic [4:0]           lo_bit, hi_bit;
	logic                 s_hit;
	logic [4:0]           s_pos;
	logic [CNT_W-1:0]     s_run;
	logic [CNT_W-1:0]     fnd, fnd_end;
	logic [CNT_W:0]       rng_end;
	logic                 accept;

	// effective total
	always_comb begin
		if (total_q == '0) begin
			tot = 13'd1;
		end else if (32'(total_q) > FRAMES) begin
			tot = 13'(TOT_CAP);
		end else begin
			tot = total_q;
		end
		tot_m1  = tot - 13'd1;
		freec   = sat_sub(tot, used_q);
		rng_end = {2'b00, req.start_frame} + {1'b0, req.count};
	end

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	bfa_map_mem #(.DEPTH(MAP_WORDS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bfa_word_search u_search (
		.word    (rdata),
		.is_last (addr_s1 == last_q),
		.lim     (tot_m1[4:0]),
		.cnt     (cnt_q),
		.run_in  (run_q),
		.hit     (s_hit),
		.pos     (s_pos),
		.run_out (s_run)
	);

	// found run bounds
	always_comb begin
		fnd     = 13'({addr_s1, 5'd0}) + {8'd0, s_pos} + 13'd1 - cnt_q;
		fnd_end = fnd + cnt_q - 13'd1;
	end

	// run mask for the word being rewritten
	always_comb begin
		lo_bit = (addr_s1 == wlo_q) ? rs_q[4:0] : 5'd0;
		hi_bit = (addr_s1 == whi_q) ? re_q[4:0] : 5'd31;
		wmask  = (FULL_WORD << lo_bit) & (FULL_WORD >> (5'd31 - hi_bit));
	end

	// memory port control
	always_comb begin
		rd_issue = 1'b0;
		mem_we   = 1'b0;
		raddr    = addr_q;
		waddr    = addr_s1;
		wdata    = set_q ? (rdata | wmask) : (rdata & ~wmask);
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				waddr  = addr_q;
				wdata  = FULL_WORD;
			end
			S_SCAN: begin
				rd_issue = !iss_done_q && !(vld_s1 && (s_hit || addr_s1 == last_q));
			end
			S_WALK: begin
				rd_issue = !iss_done_q;
				mem_we   = vld_s1;
			end
			S_FIX_RD: begin
				raddr = '0;
			end
			S_FIX_WR: begin
				mem_we = 1'b1;
				waddr  = '0;
				wdata  = rdata | 32'd1;
			end
			default: begin
				rd_issue = 1'b0;
			end
		endcase
	end

	// read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			total_q <= cfg.data;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			used_q     <= USED_RESET;
			addr_q     <= '0;
			iss_done_q <= 1'b0;
			init_q     <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(MAP_WORDS - 1)) begin
						addr_q  <= '0;
						state_q <= init_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						iss_done_q <= 1'b0;
						addr_q     <= '0;
						if (req.mode == MODE_INIT) begin
							used_q  <= tot;
							init_q  <= 1'b1;
							state_q <= S_CLEAR;
						end else if (req.mode == MODE_ALLOC) begin
							if (req.count == '0 || req.count > freec) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (req.mode == MODE_FREE || req.mode == MODE_AVAIL
							|| req.mode == MODE_RESERVE) begin
							if (req.count == '0 || rng_end > {1'b0, tot}) begin
								state_q <= S_DONE;
							end else begin
								addr_q  <= AW'({1'b0, req.start_frame} >> 5);
								state_q <= S_WALK;
								if (req.mode == MODE_RESERVE) begin
									used_q <= sat_add(used_q, req.count, tot);
								end else if (req.mode == MODE_AVAIL
									&& req.start_frame == '0) begin
									used_q <= sat_sub(used_q, req.count - 13'd1);
								end else begin
									used_q <= sat_sub(used_q, req.count);
								end
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == last_q) begin
							iss_done_q <= 1'b1;
						end
					end
					if (vld_s1 && s_hit) begin
						addr_q     <= AW'(fnd >> 5);
						iss_done_q <= 1'b0;
						used_q     <= sat_add(used_q, cnt_q, tot);
						state_q    <= S_WALK;
					end else if (vld_s1 && addr_s1 == last_q) begin
						state_q <= S_DONE;
					end
				end
				S_WALK: begin
					if (rd_issue) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == whi_q) begin
							iss_done_q <= 1'b1;
						end
					end
					if (vld_s1 && addr_s1 == whi_q) begin
						state_q <= (mode_q == MODE_AVAIL) ? S_FIX_RD : S_DONE;
					end
				end
				S_FIX_RD: begin
					state_q <= S_FIX_WR;
				end
				S_FIX_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					init_q <= 1'b0;
					if (!out_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and search bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			cnt_q    <= req.count;
			run_q    <= '0;
			frame_q  <= '0;
			last_q   <= AW'(tot_m1 >> 5);
			rs_q     <= {1'b0, req.start_frame};
			re_q     <= 13'(rng_end - 14'd1);
			wlo_q    <= AW'({1'b0, req.start_frame} >> 5);
			whi_q    <= AW'((rng_end - 14'd1) >> 5);
			set_q    <= (req.mode == MODE_RESERVE);
			status_q <= ST_OK;
			if (req.mode == MODE_ALLOC) begin
				if (req.count == '0) begin
					status_q <= ST_BAD;
				end else if (req.count > freec) begin
					status_q <= ST_OOM;
				end
			end else if (req.mode == MODE_FREE || req.mode == MODE_AVAIL
				|| req.mode == MODE_RESERVE) begin
				if (req.count == '0 || rng_end > {1'b0, tot}) begin
					status_q <= ST_BAD;
				end
			end else if (req.mode != MODE_INIT) begin
				status_q <= ST_BAD;
			end
		end else if (state_q == S_SCAN && vld_s1) begin
			if (s_hit) begin
				rs_q    <= fnd;
				re_q    <= fnd_end;
				wlo_q   <= AW'(fnd >> 5);
				whi_q   <= AW'(fnd_end >> 5);
				set_q   <= 1'b1;
				frame_q <= fnd[FRAME_W-1:0];
			end else if (addr_s1 == last_q) begin
				status_q <= ST_OOM;
			end else begin
				run_q <= s_run;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_vld_q || rsp.ready)) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_vld_q || rsp.ready)) begin
			out_status_q <= status_q;
			out_frame_q  <= frame_q;
			out_used_q   <= used_q;
			out_free_q   <= sat_sub(tot, used_q);
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.frame       = out_frame_q;
	assign rsp.used_frames = out_used_q;
	assign rsp.free_frames = out_free_q;

	// the map is never written while waiting for a request
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("map written while idle");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second item taken while busy");

	// a result appears only after the done step
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_DONE))
		else $error("result without done step");

	// rewrites touch only the word read in the cycle before
	a_walk_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK && mem_we |-> vld_s1 && $past(rd_issue))
		else $error("map rewrite without a matching read");

endmodule
